### rtl/core/lasu_pkg.sv
// Shared types and constants for the local alignment scorer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lasu_pkg;

  // Query store and score sizing
  localparam int MaxQuery  = 64;
  localparam int IdxBits   = $clog2(MaxQuery);
  localparam int LenBits   = $clog2(MaxQuery + 1);
  localparam int ScoreBits = 12;
  localparam int SumBits   = ScoreBits + 2;
  localparam int ColBits   = 16;
  localparam int SymBits   = 8;
  localparam int OpBits    = 2;
  localparam int MatchBits = 4;
  localparam int PenBits   = 5;
  localparam int CfgIdxBits = 2;
  localparam int OutDataBits = 48;

  localparam logic [LenBits-1:0] MaxQueryLen = LenBits'(MaxQuery);
  localparam logic [ColBits-1:0] ColMax      = {ColBits{1'b1}};

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] REG_MATCH    = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_GAP      = 2'd2;

  typedef enum logic [OpBits-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_PROCESS = 2'd2,
    OP_NOP     = 2'd3
  } lasu_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } lasu_state_e;

  typedef logic [ScoreBits-1:0] score_t;

  // Control group from the sequencer to the stores
  typedef struct packed {
    logic [IdxBits-1:0] rd_addr;
    logic               q_we;
    logic [IdxBits-1:0] q_waddr;
    logic [SymBits-1:0] q_wdata;
    logic               col_we;
    logic [IdxBits-1:0] col_waddr;
    score_t             col_wdata;
    logic               col_clr;
  } lasu_store_req_t;

endpackage

### rtl/core/lasu_cell_unit.sv
// Shared cell unit: one score-matrix cell with linear gap and saturation.
// Depends on lasu_pkg.
`timescale 1ns / 1ps

module lasu_cell_unit
  import lasu_pkg::*;
(
  input  score_t               diag_i,
  input  score_t               left_i,
  input  score_t               up_i,
  input  logic                 equal_i,
  input  logic [MatchBits-1:0] match_i,
  input  logic [PenBits-1:0]   mismatch_i,
  input  logic [PenBits-1:0]   gap_i,
  output score_t               cell_o
);

  localparam logic signed [SumBits-1:0] ScoreMax = SumBits'((2 ** ScoreBits) - 1);

  logic signed [SumBits-1:0] sub_s;
  logic signed [SumBits-1:0] gap_s;
  logic signed [SumBits-1:0] from_diag;
  logic signed [SumBits-1:0] from_left;
  logic signed [SumBits-1:0] from_up;
  logic signed [SumBits-1:0] best_s;

  always_comb begin
    gap_s = {{(SumBits-PenBits){gap_i[PenBits-1]}}, gap_i};
    if (equal_i) begin
      sub_s = {{(SumBits-MatchBits){1'b0}}, match_i};
    end else begin
      sub_s = {{(SumBits-PenBits){mismatch_i[PenBits-1]}}, mismatch_i};
    end
    from_diag = $signed({2'b00, diag_i}) + sub_s;
    from_left = $signed({2'b00, left_i}) + gap_s;
    from_up   = $signed({2'b00, up_i}) + gap_s;

    best_s = from_diag;
    if (from_left > best_s) best_s = from_left;
    if (from_up > best_s) best_s = from_up;

    // clamp to the score range
    if (best_s < 0) begin
      cell_o = '0;
    end else if (best_s > ScoreMax) begin
      cell_o = ScoreMax[ScoreBits-1:0];
    end else begin
      cell_o = best_s[ScoreBits-1:0];
    end
  end

endmodule

### rtl/core/lasu_store.sv
// Query symbol store and previous-column score store with registered reads.
// Depends on lasu_pkg; the column store keeps a valid bit per row.
`timescale 1ns / 1ps

module lasu_store
  import lasu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lasu_store_req_t    req_i,
  output logic [SymBits-1:0] q_rdata_o,
  output score_t             left_o
);

  logic [SymBits-1:0] q_mem [MaxQuery];
  score_t             col_mem [MaxQuery];
  logic [MaxQuery-1:0] col_vld_q;
  logic               rd_vld_q;
  logic [SymBits-1:0] q_rdata_q;
  score_t             col_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.q_we) q_mem[req_i.q_waddr] <= req_i.q_wdata;
    q_rdata_q <= q_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.col_we) col_mem[req_i.col_waddr] <= req_i.col_wdata;
    col_rdata_q <= col_mem[req_i.rd_addr];
  end

  // rows never written since clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= col_vld_q[req_i.rd_addr];
      if (req_i.col_clr) begin
        col_vld_q <= '0;
      end else if (req_i.col_we) begin
        col_vld_q[req_i.col_waddr] <= 1'b1;
      end
    end
  end

  assign q_rdata_o = q_rdata_q;
  assign left_o    = rd_vld_q ? col_rdata_q : '0;

endmodule

### rtl/core/local_alignment_scorer_unit.sv
// Top level of the local alignment scorer: sequencer, configuration and output register.
// Depends on lasu_pkg, lasu_store and lasu_cell_unit.
`timescale 1ns / 1ps

// Smith-Waterman local alignment scorer with a linear gap penalty. Send query
// symbols with opcode append (tuser = 1), then subject symbols with opcode
// process (tuser = 2); opcode clear (tuser = 0) empties the query and the
// score column, opcode 3 does nothing. Every item gives exactly one result
// item: the bottom cell of the column just computed (0 for non-process items),
// the best cell since the last clear with its 1-based row and column, and a
// status flag that is set when an append finds the 64-entry query store full.
// Scores saturate at 4095 and never go below zero; the subject column count
// stops at 65535. For a process item one shared cell unit walks the column
// one row per cycle, fed by the single read port of the column store, whose
// read data is registered. A finished result waits in the output register;
// the block takes the next item meanwhile but holds its own next result
// until the output register is free. There is no clearing pass after reset.
// Write the match, mismatch and gap registers only while the block is idle.
module local_alignment_scorer_unit
  import lasu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]             s_axis_tuser,   // [1:0] opcode
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [11:0] bottom_score, [23:12] best_score, [30:24] best_row,
  // [46:31] best_column, [47] zero
  output logic [OutDataBits-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,   // [0] status
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [PenBits-1:0]     cfg_data_i
);

  lasu_state_e state_q, state_d;

  logic [MatchBits-1:0] match_q;
  logic [PenBits-1:0]   mismatch_q;
  logic [PenBits-1:0]   gap_q;

  logic [LenBits-1:0] len_q, len_d;
  logic [ColBits-1:0] col_cnt_q, col_cnt_d;
  score_t             best_q, best_d;
  logic [LenBits-1:0] best_row_q, best_row_d;
  logic [ColBits-1:0] best_col_q, best_col_d;

  logic [SymBits-1:0] sym_q, sym_d;
  logic [LenBits-1:0] rd_idx_q, rd_idx_d;
  logic [LenBits-1:0] wr_idx_q, wr_idx_d;
  logic               cmp_v_q, cmp_v_d;
  score_t             diag_q, diag_d;
  score_t             up_q, up_d;
  logic               status_q, status_d;

  logic                   out_valid_q, out_valid_d;
  logic [OutDataBits-1:0] out_data_q;
  logic                   out_user_q;
  logic                   out_load;

  lasu_store_req_t    store_req;
  logic [SymBits-1:0] q_sym;
  score_t             left;
  score_t             cell_score;

  lasu_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .q_rdata_o (q_sym),
    .left_o    (left)
  );

  lasu_cell_unit u_cell (
    .diag_i     (diag_q),
    .left_i     (left),
    .up_i       (up_q),
    .equal_i    (q_sym == sym_q),
    .match_i    (match_q),
    .mismatch_i (mismatch_q),
    .gap_i      (gap_q),
    .cell_o     (cell_score)
  );

  // Configuration registers: always ready, index 3 is ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= MatchBits'(1);
      mismatch_q <= {PenBits{1'b1}};
      gap_q      <= {{(PenBits-1){1'b1}}, 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MATCH:    match_q    <= cfg_data_i[MatchBits-1:0];
        REG_MISMATCH: mismatch_q <= cfg_data_i;
        REG_GAP:      gap_q      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Sequencer: accept in idle, walk the column in run, hand off in done
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    col_cnt_d   = col_cnt_q;
    best_d      = best_q;
    best_row_d  = best_row_q;
    best_col_d  = best_col_q;
    sym_d       = sym_q;
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    cmp_v_d     = cmp_v_q;
    diag_d      = diag_q;
    up_d        = up_q;
    status_d    = status_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;

    store_req           = '0;
    store_req.rd_addr   = rd_idx_q[IdxBits-1:0];
    store_req.col_waddr = wr_idx_q[IdxBits-1:0];
    store_req.col_wdata = cell_score;
    store_req.q_waddr   = len_q[IdxBits-1:0];
    store_req.q_wdata   = s_axis_tdata;

    s_axis_tready = (state_q == ST_IDLE);

    // drop the result once the sink takes it
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          sym_d    = s_axis_tdata;
          rd_idx_d = '0;
          wr_idx_d = '0;
          cmp_v_d  = 1'b0;
          diag_d   = '0;
          up_d     = '0;
          status_d = 1'b0;
          state_d  = ST_DONE;
          unique case (lasu_op_e'(s_axis_tuser))
            OP_CLEAR: begin
              len_d             = '0;
              col_cnt_d         = '0;
              best_d            = '0;
              best_row_d        = '0;
              best_col_d        = '0;
              store_req.col_clr = 1'b1;
            end
            OP_APPEND: begin
              if (len_q == MaxQueryLen) begin
                status_d = 1'b1;
              end else begin
                store_req.q_we = 1'b1;
                len_d          = len_q + 1'b1;
              end
            end
            OP_PROCESS: begin
              if (col_cnt_q != ColMax) col_cnt_d = col_cnt_q + 1'b1;
              state_d = ST_RUN;
            end
            default: ;
          endcase
        end
      end

      ST_RUN: begin
        // issue the next row read
        cmp_v_d = 1'b0;
        if (rd_idx_q < len_q) begin
          rd_idx_d = rd_idx_q + 1'b1;
          cmp_v_d  = 1'b1;
        end
        // score the row whose read data is back
        if (cmp_v_q) begin
          store_req.col_we = 1'b1;
          diag_d           = left;
          up_d             = cell_score;
          wr_idx_d         = wr_idx_q + 1'b1;
          if (cell_score > best_q) begin
            best_d     = cell_score;
            best_row_d = wr_idx_q + 1'b1;
            best_col_d = col_cnt_q;
          end
        end
        if ((rd_idx_q == len_q) && !cmp_v_q) state_d = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_load    = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      col_cnt_q   <= '0;
      best_q      <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
      sym_q       <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      cmp_v_q     <= 1'b0;
      diag_q      <= '0;
      up_q        <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      col_cnt_q   <= col_cnt_d;
      best_q      <= best_d;
      best_row_q  <= best_row_d;
      best_col_q  <= best_col_d;
      sym_q       <= sym_d;
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      cmp_v_q     <= cmp_v_d;
      diag_q      <= diag_d;
      up_q        <= up_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: up holds the bottom cell, zero for non-process items
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, best_col_q, best_row_q, best_q, up_q};
      out_user_q <= status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### rtl/core/lasu_checker.sv
// Port-level checker for the local alignment scorer, bound to the top level.
// Depends on lasu_pkg and local_alignment_scorer_unit.
`timescale 1ns / 1ps

module lasu_checker
  import lasu_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OutDataBits-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  // hold a stalled result
  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result valid dropped while stalled");

  a_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result payload changed while stalled");

  // the bottom cell was compared against the best before it is shown
  a_bottom_le_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:0] <= m_axis_tdata[23:12]))
    else $error("bottom score above best score");

  // a dropped append reports no column
  a_full_no_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[11:0] == '0))
    else $error("store-full result with nonzero bottom score");

  // no best position without a positive best score
  a_zero_best_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[23:12] == '0) |->
      (m_axis_tdata[30:24] == '0) && (m_axis_tdata[46:31] == '0))
    else $error("best position set with zero best score");

endmodule

bind local_alignment_scorer_unit lasu_checker u_lasu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
